// File: hdl/ycc2rgb_pkg.sv
// ycc2rgb_pkg: shared types, constants and the coefficient table of the
// YCbCr to RGB converter. No dependencies.
package ycc2rgb_pkg;

  // Luma scale (1.164 in 16.16), the 16.16 rounding half and half the luma scale
  localparam int unsigned YScale    = 76309;
  localparam int unsigned RoundHalf = 32768;
  localparam int unsigned DivHalf   = 38154;
  // floor(2^32 / YScale), the reciprocal used for the chroma divide
  localparam int unsigned Recip     = 56283;

  localparam int CoefW  = 18;  // widest coefficient is 138453
  localparam int NumW   = 25;  // coef * |chroma| + DivHalf
  localparam int OffW   = 9;   // signed chroma offset
  localparam int SumW   = 11;  // signed Y + offsets - 16
  localparam int ScaleW = 30;  // signed scaled channel

  // Register indexes on the configuration port
  localparam logic [1:0] REG_COEF_SET  = 2'd0;
  localparam logic [1:0] REG_PIX_FMT   = 2'd1;
  localparam logic [1:0] REG_CHAN_ORD  = 2'd2;

  typedef enum logic [1:0] {
    FMT_XRGB32 = 2'd0,
    FMT_RGB24  = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_RGB555 = 2'd3
  } pix_fmt_t;

  typedef struct packed {
    logic [CoefW-1:0] crv;
    logic [CoefW-1:0] cbu;
    logic [CoefW-1:0] cgu;
    logic [CoefW-1:0] cgv;
  } coef_row_t;

  // Stage load enables handed to the divide lanes
  typedef struct packed {
    logic ld2;
    logic ld3;
  } adv_t;

  function automatic coef_row_t coef_row(input logic [2:0] sel);
    coef_row_t c;
    unique case (sel)
      3'd0, 3'd1: c = '{crv: 18'd117504, cbu: 18'd138453, cgu: 18'd13954, cgv: 18'd34903};
      3'd4:       c = '{crv: 18'd104448, cbu: 18'd132798, cgu: 18'd24759, cgv: 18'd53109};
      3'd7:       c = '{crv: 18'd117579, cbu: 18'd136230, cgu: 18'd16907, cgv: 18'd35559};
      default:    c = '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279};
    endcase
    return c;
  endfunction

endpackage

// File: hdl/ycbcr_to_rgb_pixel_converter.sv
// An accepted item moves through stage registers 1 to 6; stage 6 is the output register.
// Throughput: one item per cycle while out_stall is low; the six-stage pipeline
// holds up to six items. Each stage has its own valid bit and loads when empty or
// when the next stage loads, so bubbles close up and a stall at the output backs
// up stage by stage.
// Reset (rst_n low, synchronous) empties the pipeline and restores
// coefficient_set 6, pixel_format 0, channel_order 0.
module ycbcr_to_rgb_pixel_converter
  import ycc2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_luma,
  input  logic [7:0]  in_chroma_blue,
  input  logic [7:0]  in_chroma_red,
  input  logic        in_row_end,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel,
  output logic        out_row_end_out
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [2:0] coef_set_r;
  pix_fmt_t   pix_fmt_r;
  logic       chan_ord_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_set_r <= 3'd6;
      pix_fmt_r  <= FMT_XRGB32;
      chan_ord_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COEF_SET: coef_set_r <= cfg_data;
        REG_PIX_FMT:  pix_fmt_r  <= pix_fmt_t'(cfg_data[1:0]);
        REG_CHAN_ORD: chan_ord_r <= cfg_data[0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: valid bit and load enable per stage
  // ---------------------------------------------------------------------
  logic [6:1] vld_r;
  logic [6:1] ld;
  adv_t       adv;

  always_comb begin
    ld[6] = !vld_r[6] || !out_stall;
    for (int k = 5; k >= 1; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_stall = !ld[1];
  assign adv      = '{ld2: ld[2], ld3: ld[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (ld[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: center chroma, multiply magnitudes by the coefficients
  // ---------------------------------------------------------------------
  coef_row_t          coef;
  logic signed [8:0]  cb_c;
  logic signed [8:0]  cr_c;
  logic [7:0]         cb_mag;
  logic [7:0]         cr_mag;
  logic [NumW-1:0]    p_rv, p_bu, p_gu, p_gv;

  logic [NumW-1:0]    n_rv_r, n_bu_r, n_gu_r, n_gv_r;
  logic               cb_neg_r, cr_neg_r;
  logic [7:0]         y_s1_r, y_s2_r, y_s3_r;
  logic [5:1]         re_r;

  assign coef   = coef_row(coef_set_r);
  assign cb_c   = $signed({1'b0, in_chroma_blue}) - 9'sd128;
  assign cr_c   = $signed({1'b0, in_chroma_red}) - 9'sd128;
  assign cb_mag = cb_c[8] ? 8'(-cb_c) : cb_c[7:0];
  assign cr_mag = cr_c[8] ? 8'(-cr_c) : cr_c[7:0];

  assign p_rv = NumW'(coef.crv) * NumW'(cr_mag);
  assign p_bu = NumW'(coef.cbu) * NumW'(cb_mag);
  assign p_gu = NumW'(coef.cgu) * NumW'(cb_mag);
  assign p_gv = NumW'(coef.cgv) * NumW'(cr_mag);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      n_rv_r   <= p_rv + NumW'(DivHalf);
      n_bu_r   <= p_bu + NumW'(DivHalf);
      n_gu_r   <= p_gu + NumW'(DivHalf);
      n_gv_r   <= p_gv + NumW'(DivHalf);
      cb_neg_r <= cb_c[8];
      cr_neg_r <= cr_c[8];
      y_s1_r   <= in_luma;
      re_r[1]  <= in_row_end;
    end
    if (ld[2]) begin
      y_s2_r  <= y_s1_r;
      re_r[2] <= re_r[1];
    end
    if (ld[3]) begin
      y_s3_r  <= y_s2_r;
      re_r[3] <= re_r[2];
    end
    if (ld[4]) re_r[4] <= re_r[3];
    if (ld[5]) re_r[5] <= re_r[4];
  end

  // ---------------------------------------------------------------------
  // Stages 2-3: rounded divide, half away from zero; green terms negated
  // ---------------------------------------------------------------------
  logic signed [OffW-1:0] rv, bu, gu, gv;

  ycc2rgb_rdiv u_div_rv (.clk(clk), .adv(adv), .num(n_rv_r), .neg(cr_neg_r),  .q_out(rv));
  ycc2rgb_rdiv u_div_bu (.clk(clk), .adv(adv), .num(n_bu_r), .neg(cb_neg_r),  .q_out(bu));
  ycc2rgb_rdiv u_div_gu (.clk(clk), .adv(adv), .num(n_gu_r), .neg(!cb_neg_r), .q_out(gu));
  ycc2rgb_rdiv u_div_gv (.clk(clk), .adv(adv), .num(n_gv_r), .neg(!cr_neg_r), .q_out(gv));

  // ---------------------------------------------------------------------
  // Stage 4: add offsets to luma, remove the black level
  // ---------------------------------------------------------------------
  logic signed [SumW-1:0] y_s;
  logic signed [SumW-1:0] v_r_r, v_g_r, v_b_r;

  assign y_s = $signed({3'b000, y_s3_r}) - 11'sd16;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      v_r_r <= y_s + SumW'(rv);
      v_g_r <= y_s + SumW'(gu) + SumW'(gv);
      v_b_r <= y_s + SumW'(bu);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: scale by the luma gain and add the rounding half
  // ---------------------------------------------------------------------
  localparam logic signed [ScaleW-1:0] GainS  = ScaleW'(YScale);
  localparam logic signed [ScaleW-1:0] RoundS = ScaleW'(RoundHalf);

  logic signed [ScaleW-1:0] t_r_r, t_g_r, t_b_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      t_r_r <= GainS * ScaleW'(v_r_r) + RoundS;
      t_g_r <= GainS * ScaleW'(v_g_r) + RoundS;
      t_b_r <= GainS * ScaleW'(v_b_r) + RoundS;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: saturate, order and pack into the output register
  // ---------------------------------------------------------------------
  function automatic logic [7:0] sat8(input logic signed [ScaleW-1:0] t);
    logic [7:0] s;
    if (t[ScaleW-1]) begin
      s = 8'd0;
    end else if (|t[ScaleW-2:24]) begin
      s = 8'd255;
    end else begin
      s = t[23:16];
    end
    return s;
  endfunction

  logic [7:0]  ch_r, ch_g, ch_b, ch_hi, ch_lo;
  logic [31:0] pix_nxt;
  logic [31:0] pix_r;
  logic        re_out_r;

  assign ch_r  = sat8(t_r_r);
  assign ch_g  = sat8(t_g_r);
  assign ch_b  = sat8(t_b_r);
  assign ch_hi = chan_ord_r ? ch_b : ch_r;
  assign ch_lo = chan_ord_r ? ch_r : ch_b;

  always_comb begin
    unique case (pix_fmt_r)
      FMT_XRGB32: pix_nxt = {8'h00, ch_hi, ch_g, ch_lo};
      FMT_RGB24:  pix_nxt = {8'h00, ch_lo, ch_g, ch_hi};  // first byte in bits 7:0
      FMT_RGB565: pix_nxt = {16'h0000, ch_hi[7:3], ch_g[7:2], ch_lo[7:3]};
      FMT_RGB555: pix_nxt = {16'h0000, 1'b0, ch_hi[7:3], ch_g[7:3], ch_lo[7:3]};
      default:    pix_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      pix_r    <= pix_nxt;
      re_out_r <= re_r[5];
    end
  end

  assign out_valid       = vld_r[6];
  assign out_pixel       = pix_r;
  assign out_row_end_out = re_out_r;

endmodule

// File: hdl/ycc2rgb_rdiv.sv
// ycc2rgb_rdiv: two-stage rounded divide by the luma scale, one chroma term.
// Depends on ycc2rgb_pkg.
module ycc2rgb_rdiv
  import ycc2rgb_pkg::*;
(
  input  logic                  clk,
  input  adv_t                  adv,
  input  logic [NumW-1:0]       num,     // |coef * chroma| + DivHalf
  input  logic                  neg,     // result sign
  output logic signed [OffW-1:0] q_out
);

  localparam int PrdW = NumW + 16;

  logic [PrdW-1:0]  recip_prod;
  logic [7:0]       q0_nxt;
  logic [7:0]       q0_r;
  logic [NumW-1:0]  num_r;
  logic             neg_r;
  logic [NumW-1:0]  back_prod;
  logic [NumW-1:0]  rem;
  logic [OffW-1:0]  q_mag;
  logic signed [OffW-1:0] q_nxt;
  logic signed [OffW-1:0] q_r;

  // Estimate: never high, at most one low
  assign recip_prod = PrdW'(num) * PrdW'(Recip);
  assign q0_nxt     = recip_prod[39:32];

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      q0_r  <= q0_nxt;
      num_r <= num;
      neg_r <= neg;
    end
  end

  // Correct the estimate by one compare and step
  assign back_prod = NumW'(q0_r) * NumW'(YScale);
  assign rem       = num_r - back_prod;
  assign q_mag     = {1'b0, q0_r} + OffW'(rem >= NumW'(YScale));
  assign q_nxt     = neg_r ? -$signed(q_mag) : $signed(q_mag);

  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

// File: hdl/ycc2rgb_chk.sv
// ycc2rgb_chk: port-level checks on the YCbCr to RGB converter, bound to the
// top level. Depends only on the top level's ports.
module ycc2rgb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pixel,
  input logic        out_row_end_out
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty output register never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // Every format leaves the top byte clear
  a_top_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel[31:24] == 8'h00)
    else $error("pixel has bits set above bit 23");

  // A stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(out_row_end_out))
    else $error("stalled result changed");

endmodule

bind ycbcr_to_rgb_pixel_converter ycc2rgb_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel       (out_pixel),
  .out_row_end_out (out_row_end_out)
);

// File: tb/ycbcr_to_rgb_pixel_converter_tb.sv
// ycbcr_to_rgb_pixel_converter_tb: self-checking bench for the YCbCr to RGB converter.
// Holds a pixel predictor class and the drivers; depends on ycc2rgb_pkg and the RTL only.
module ycbcr_to_rgb_pixel_converter_tb;
  import ycc2rgb_pkg::*;

  // Pipeline depth given at the head of the block, used for drain pauses
  localparam int PipeLatency   = 6;
  localparam int WatchdogLimit = 2000;
  localparam int NumPhases     = 11;
  localparam int ItemsPerPhase = 120;
  // Index past the register list; writes to it must be ignored
  localparam logic [1:0] RegUnmapped = 2'd3;

  typedef struct {
    logic [31:0] pixel;
    logic        row_end;
  } pixel_item_t;

  // Predicts the packed pixel of each accepted sample and queues it until the
  // matching result arrives.
  class rgb_predictor;
    localparam longint LumaGain  = 76309;
    localparam longint LumaRound = 32768;
    localparam longint QuotHalf  = 38154;

    int crv_tab[8] = '{117504, 117504, 104597, 104597, 104448, 104597, 104597, 117579};
    int cbu_tab[8] = '{138453, 138453, 132201, 132201, 132798, 132201, 132201, 136230};
    int cgu_tab[8] = '{13954, 13954, 25675, 25675, 24759, 25675, 25675, 16907};
    int cgv_tab[8] = '{34903, 34903, 53279, 53279, 53109, 53279, 53279, 35559};

    logic [2:0]  coef_sel;
    pix_fmt_t    fmt;
    logic        blue_first;
    pixel_item_t expected_pixels[$];
    int          errors;

    function new();
      coef_sel   = 3'd6;
      fmt        = FMT_XRGB32;
      blue_first = 1'b0;
      errors     = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [2:0] data);
      case (idx)
        REG_COEF_SET: coef_sel = data;
        REG_PIX_FMT:  fmt = pix_fmt_t'(data[1:0]);
        REG_CHAN_ORD: blue_first = data[0];
        default: ;
      endcase
    endfunction

    // Quotient by the luma gain, rounded half away from zero
    function int quot_round(longint num);
      if (num > 0) return int'((num + QuotHalf) / LumaGain);
      return -int'((-num + QuotHalf) / LumaGain);
    endfunction

    function logic [7:0] clamp_level(int v);
      longint t;
      t = LumaGain * longint'(v - 16) + LumaRound;
      if (t < 0) return 8'd0;
      t = t / 65536;
      if (t > 255) return 8'd255;
      return t[7:0];
    endfunction

    function void note_input(logic [7:0] luma, logic [7:0] cb_in, logic [7:0] cr_in,
                             logic row_end);
      int          cb, cr, rv, bu, gu, gv;
      logic [7:0]  r, g, b, hi, lo;
      pixel_item_t item;
      cb = int'(cb_in) - 128;
      cr = int'(cr_in) - 128;
      rv = quot_round(longint'(crv_tab[coef_sel]) * cr);
      bu = quot_round(longint'(cbu_tab[coef_sel]) * cb);
      gu = quot_round(-longint'(cgu_tab[coef_sel]) * cb);
      gv = quot_round(-longint'(cgv_tab[coef_sel]) * cr);
      r = clamp_level(int'(luma) + rv);
      g = clamp_level(int'(luma) + gu + gv);
      b = clamp_level(int'(luma) + bu);
      hi = blue_first ? b : r;
      lo = blue_first ? r : b;
      case (fmt)
        FMT_XRGB32: item.pixel = {8'h00, hi, g, lo};
        FMT_RGB24:  item.pixel = {8'h00, lo, g, hi};
        FMT_RGB565: item.pixel = {16'h0000, hi[7:3], g[7:2], lo[7:3]};
        default:    item.pixel = {16'h0000, 1'b0, hi[7:3], g[7:3], lo[7:3]};
      endcase
      item.row_end = row_end;
      expected_pixels.push_back(item);
    endfunction

    function void check_result(logic [31:0] pixel, logic row_end);
      pixel_item_t want;
      if (expected_pixels.size() == 0) begin
        $error("pixel: no item expected, actual %h", pixel);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (pixel !== want.pixel) begin
        $error("pixel: expected %h, actual %h", want.pixel, pixel);
        errors++;
      end
      if (row_end !== want.row_end) begin
        $error("row_end_out: expected %b, actual %b", want.row_end, row_end);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [2:0]  cfg_data = 3'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_luma = 8'd0;
  logic [7:0]  in_chroma_blue = 8'd0;
  logic [7:0]  in_chroma_red = 8'd0;
  logic        in_row_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_pixel;
  logic        out_row_end_out;

  rgb_predictor pred = new();
  // Cleared for stretches in which both sides run back to back
  bit idle_on = 1'b1;

  ycbcr_to_rgb_pixel_converter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_luma         (in_luma),
    .in_chroma_blue  (in_chroma_blue),
    .in_chroma_red   (in_chroma_red),
    .in_row_end      (in_row_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel),
    .out_row_end_out (out_row_end_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias samples toward the corners so saturation is hit often
  function automatic logic [7:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'd128;
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: check every accepted item, then pick the stall for the next cycle.
  // Sampling right after the edge sees the values the block saw at that edge.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pred.check_result(out_pixel, out_row_end_out);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Present one sample, hold it until the block takes it, and record the prediction.
  // Valid stays high into the next item when no gap follows.
  task automatic drive_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr,
                             logic row_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_luma        <= luma;
    in_chroma_blue <= cb;
    in_chroma_red  <= cr;
    in_row_end     <= row_end;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pred.note_input(luma, cb, cr, row_end);
  endtask

  // Leave cfg_valid high so back-to-back writes need no re-raise; the caller drops it
  task automatic write_reg(logic [1:0] idx, logic [2:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    pred.set_register(idx, data);
  endtask

  // Wait for every expected pixel, then let the pipeline settle
  task automatic wait_drained();
    while (pred.pending() != 0) @(posedge clk);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  task automatic drive_directed();
    logic [7:0] y, cb, cr;
    // Every corner of the sample cube: exercises both saturation limits
    for (int k = 0; k < 8; k++) begin
      y  = k[0] ? 8'd255 : 8'd0;
      cb = k[1] ? 8'd255 : 8'd0;
      cr = k[2] ? 8'd255 : 8'd0;
      drive_pixel(y, cb, cr, k[0] ^ k[1] ^ k[2]);
    end
    // Neutral chroma at the nominal and full luma range ends and mid scale
    drive_pixel(8'd128, 8'd128, 8'd128, 1'b1);
    drive_pixel(8'd16, 8'd128, 8'd128, 1'b0);
    drive_pixel(8'd235, 8'd128, 8'd128, 1'b0);
    drive_pixel(8'd255, 8'd128, 8'd128, 1'b0);
    drive_pixel(8'd0, 8'd128, 8'd128, 1'b1);
    // Saturated primaries and opposed chroma
    drive_pixel(8'd81, 8'd90, 8'd240, 1'b0);
    drive_pixel(8'd145, 8'd54, 8'd34, 1'b0);
    drive_pixel(8'd41, 8'd240, 8'd110, 1'b1);
    drive_pixel(8'd128, 8'd0, 8'd255, 1'b0);
    drive_pixel(8'd128, 8'd255, 8'd0, 1'b1);
  endtask

  // Random pixels laid out as rows of random length, with a little row_end noise
  task automatic drive_random(int count);
    int col, row_len;
    logic row_end;
    col     = 0;
    row_len = $urandom_range(1, 40);
    for (int n = 0; n < count; n++) begin
      // Switch between idling and back-to-back stretches
      if (n % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
      col++;
      row_end = (col == row_len);
      if ($urandom_range(0, 9) == 0) row_end = ~row_end;
      if (col == row_len) begin
        col     = 0;
        row_len = $urandom_range(1, 40);
      end
      drive_pixel(pick_sample(), pick_sample(), pick_sample(), row_end);
    end
  endtask

  initial begin : stimulus
    logic [2:0] coef, fmt_data, ord_data;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0) begin
        // Reset settings first
        drive_directed();
      end else begin
        wait_drained();
        coef     = 3'($urandom_range(0, 7));
        fmt_data = 3'($urandom_range(0, 7));
        ord_data = 3'($urandom_range(0, 7));
        // Walk every coefficient set, and each format under both channel orders;
        // the upper data bits are random to check masking to the field width
        if (ph <= 8) begin
          coef          = 3'(ph - 1);
          fmt_data[1:0] = 2'((ph - 1) % 4);
          ord_data[0]   = ((ph - 1) >= 4);
        end
        write_reg(REG_COEF_SET, coef);
        write_reg(REG_PIX_FMT, fmt_data);
        write_reg(RegUnmapped, 3'($urandom_range(0, 7)));
        write_reg(REG_CHAN_ORD, ord_data);
        cfg_valid <= 1'b0;
      end
      drive_random(ItemsPerPhase);
      in_valid <= 1'b0;
    end

    wait_drained();
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ycc2rgb_pkg.sv
hdl/ycc2rgb_rdiv.sv
hdl/ycbcr_to_rgb_pixel_converter.sv
hdl/ycc2rgb_chk.sv
tb/ycbcr_to_rgb_pixel_converter_tb.sv
